FILE: hdl/slr_pkg.sv
// ----------------------------------------------------------------------------
// Subtitle line router package
// Character codes, result codes, line scan state and the match words.
// ----------------------------------------------------------------------------
package slr_pkg;

	// Result codes as they appear on the output item.
	localparam logic [1:0] ROUTE_BOTH   = 2'd0;
	localparam logic [1:0] ROUTE_TEXT   = 2'd1;
	localparam logic [1:0] ROUTE_EFFECT = 2'd2;

	localparam logic [1:0] SEC_CODE_HEADER = 2'd0;
	localparam logic [1:0] SEC_CODE_EVENTS = 2'd1;
	localparam logic [1:0] SEC_CODE_FOOTER = 2'd2;

	// Characters.
	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_P_LO     = 8'h70;
	localparam logic [7:0] CH_P_UP     = 8'h50;
	localparam logic [7:0] CH_DIGIT_0  = 8'h30;
	localparam logic [7:0] CH_DIGIT_9  = 8'h39;

	localparam logic [3:0] EVENTS_LEN   = 4'd8;
	localparam logic [3:0] DIALOGUE_LEN = 4'd9;
	localparam logic [3:0] LEN_MAX      = 4'd15;

	// Per-line scan state.
	typedef struct packed {
		logic [3:0]  len;
		logic        ev_ok;
		logic        lead;
		logic [3:0]  dlg_idx;
		logic        dlg_fail;
		logic        first_br;
		logic        draw;
		logic [15:0] prev;
		logic        ret;
	} line_st_t;

	localparam line_st_t LINE_CLEAR = '{
		len: 4'd0, ev_ok: 1'b1, lead: 1'b1, dlg_idx: 4'd0, dlg_fail: 1'b0,
		first_br: 1'b0, draw: 1'b0, prev: 16'h0000, ret: 1'b0
	};

	// What the section tracker needs to know about a finished line.
	typedef struct packed {
		logic [3:0] len;
		logic       ev_ok;
		logic       first_br;
		logic       dlg_ok;
		logic       draw;
	} line_sum_t;

	function automatic logic [7:0] events_char(input logic [2:0] idx);
		logic [7:0] ch;
		begin
			case (idx)
				3'd0: ch = 8'h5B; // [
				3'd1: ch = 8'h45; // E
				3'd2: ch = 8'h76; // v
				3'd3: ch = 8'h65; // e
				3'd4: ch = 8'h6E; // n
				3'd5: ch = 8'h74; // t
				3'd6: ch = 8'h73; // s
				default: ch = 8'h5D; // ]
			endcase
			return ch;
		end
	endfunction

	function automatic logic [7:0] dialogue_char(input logic [3:0] idx);
		logic [7:0] ch;
		begin
			case (idx)
				4'd0: ch = 8'h44; // D
				4'd1: ch = 8'h69; // i
				4'd2: ch = 8'h61; // a
				4'd3: ch = 8'h6C; // l
				4'd4: ch = 8'h6F; // o
				4'd5: ch = 8'h67; // g
				4'd6: ch = 8'h75; // u
				4'd7: ch = 8'h65; // e
				4'd8: ch = 8'h3A; // :
				default: ch = 8'h00;
			endcase
			return ch;
		end
	endfunction

endpackage

FILE: hdl/slr_char_if.sv
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one script byte or an end-of-stream mark.
// ----------------------------------------------------------------------------
interface slr_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_req;
	logic       flush;

	modport source (output valid, output byte_req, output flush, input ready);
	modport sink (input valid, input byte_req, input flush, output ready);
endinterface

FILE: hdl/slr_route_if.sv
// ----------------------------------------------------------------------------
// Route channel
// Valid/ready channel carrying one routing decision per finished line.
// ----------------------------------------------------------------------------
interface slr_route_if;
	logic       valid;
	logic       ready;
	logic [1:0] route;
	logic [1:0] section;

	modport source (output valid, output route, output section, input ready);
	modport sink (input valid, input route, input section, output ready);
endinterface

FILE: hdl/slr_line_scan.sv
// ----------------------------------------------------------------------------
// Line scanner
// Folds each byte into the running line state and flags line ends.
// ----------------------------------------------------------------------------
module slr_line_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        byte_req,
	input  logic              flush,
	output logic              line_end,
	output slr_pkg::line_sum_t summary
);
	import slr_pkg::*;

	line_st_t st_q;
	line_st_t st_a;
	line_st_t st_n;

	function automatic line_st_t take_char(input line_st_t s, input logic [7:0] c);
		line_st_t   r;
		logic [7:0] older;
		logic [7:0] newer;
		logic       c_is_p;
		logic       n_is_p;
		logic       c_is_dig;
		begin
			r        = s;
			older    = s.prev[15:8];
			newer    = s.prev[7:0];
			c_is_p   = (c == CH_P_LO) || (c == CH_P_UP);
			n_is_p   = (newer == CH_P_LO) || (newer == CH_P_UP);
			c_is_dig = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
			// Both drawing windows need two earlier characters of this line.
			if (s.len >= 4'd2) begin
				if (older == CH_LBRACE && newer == CH_BSLASH && c_is_p)
					r.draw = 1'b1;
				if (older == CH_BSLASH && n_is_p && c_is_dig)
					r.draw = 1'b1;
			end
			if (s.len < EVENTS_LEN) begin
				if (c != events_char(s.len[2:0]))
					r.ev_ok = 1'b0;
			end else begin
				r.ev_ok = 1'b0;
			end
			if (s.len == 4'd0 && c == CH_LBRACKET)
				r.first_br = 1'b1;
			if (!(s.lead && (c == CH_SPACE || c == CH_TAB))) begin
				r.lead = 1'b0;
				if (!s.dlg_fail && s.dlg_idx < DIALOGUE_LEN) begin
					if (c == dialogue_char(s.dlg_idx))
						r.dlg_idx = s.dlg_idx + 4'd1;
					else
						r.dlg_fail = 1'b1;
				end
			end
			r.prev = {newer, c};
			if (s.len < LEN_MAX)
				r.len = s.len + 4'd1;
			return r;
		end
	endfunction

	always_comb begin
		line_end = 1'b0;
		st_a     = st_q;
		st_a.ret = 1'b0;
		st_n     = st_q;
		if (flush) begin
			line_end = (st_q.len != 4'd0) || st_q.ret;
			st_n     = LINE_CLEAR;
		end else if (byte_req == CH_NL) begin
			line_end = 1'b1;
			st_n     = LINE_CLEAR;
		end else begin
			// A held carriage return turns out to be part of the line.
			if (st_q.ret)
				st_a = take_char(st_a, CH_CR);
			if (byte_req == CH_CR) begin
				st_n     = st_a;
				st_n.ret = 1'b1;
			end else begin
				st_n = take_char(st_a, byte_req);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LINE_CLEAR;
		end else if (fire) begin
			st_q <= st_n;
		end
	end

	assign summary.len      = st_q.len;
	assign summary.ev_ok    = st_q.ev_ok;
	assign summary.first_br = st_q.first_br;
	assign summary.dlg_ok   = !st_q.dlg_fail && (st_q.dlg_idx == DIALOGUE_LEN);
	assign summary.draw     = st_q.draw;

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && line_end |=> st_q.len == 4'd0 && !st_q.ret)
		else $error("line state not cleared after line end");

	a_empty_line_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.len == 4'd0 |-> st_q.lead && !st_q.first_br && !st_q.draw
			&& st_q.dlg_idx == 4'd0)
		else $error("empty line carries match state");

	a_draw_needs_three: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.draw |-> st_q.len >= 4'd3)
		else $error("drawing tag flagged on a line shorter than three characters");

endmodule

FILE: hdl/slr_section_track.sv
// ----------------------------------------------------------------------------
// Section tracker
// Moves through header, events and footer and registers each line's route.
// ----------------------------------------------------------------------------
module slr_section_track (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              line_end,
	input  slr_pkg::line_sum_t summary,
	input  logic              out_ready,
	output logic              out_free,
	output logic              out_valid,
	output logic [1:0]        route,
	output logic [1:0]        section
);
	import slr_pkg::*;

	typedef enum logic [2:0] {
		SEC_HEADER = 3'b001,
		SEC_EVENTS = 3'b010,
		SEC_FOOTER = 3'b100
	} sec_st_t;

	sec_st_t    sec_q;
	sec_st_t    sec_n;
	logic [1:0] route_n;
	logic [1:0] sec_code_n;
	logic       emit;
	logic       out_valid_q;
	logic [1:0] route_q;
	logic [1:0] section_q;

	always_comb begin
		sec_n   = sec_q;
		route_n = ROUTE_BOTH;
		unique case (sec_q)
			SEC_HEADER: begin
				if (summary.ev_ok && summary.len == EVENTS_LEN)
					sec_n = SEC_EVENTS;
			end
			SEC_EVENTS: begin
				if (summary.first_br)
					sec_n = SEC_FOOTER;
				else if (summary.dlg_ok)
					route_n = summary.draw ? ROUTE_EFFECT : ROUTE_TEXT;
			end
			SEC_FOOTER: begin
				sec_n = SEC_FOOTER;
			end
			default: begin
				sec_n = SEC_FOOTER;
			end
		endcase
	end

	always_comb begin
		unique case (sec_n)
			SEC_HEADER: sec_code_n = SEC_CODE_HEADER;
			SEC_EVENTS: sec_code_n = SEC_CODE_EVENTS;
			default:    sec_code_n = SEC_CODE_FOOTER;
		endcase
	end

	assign out_free = !out_valid_q || out_ready;
	assign emit     = fire && line_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q       <= SEC_HEADER;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				sec_q <= sec_n;
			if (out_free)
				out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			route_q   <= route_n;
			section_q <= sec_code_n;
		end
	end

	assign out_valid = out_valid_q;
	assign route     = route_q;
	assign section   = section_q;

	a_footer_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q == SEC_FOOTER |=> sec_q == SEC_FOOTER)
		else $error("section left footer");

	a_header_to_events: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q == SEC_HEADER |=> sec_q == SEC_HEADER || sec_q == SEC_EVENTS)
		else $error("section skipped events");

	a_route_in_events: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && route_q != ROUTE_BOTH |-> section_q == SEC_CODE_EVENTS)
		else $error("single-output route outside events");

endmodule

FILE: hdl/subtitle_line_router.sv
// ----------------------------------------------------------------------------
// Subtitle line router
// Scans a subtitle script byte by byte and gives one route per line.
//
//   channel  role   payload                 meaning
//   chars    sink   byte_req[7:0], flush    one script byte or end of stream
//   routes   source route[1:0], section[1:0] decision for one finished line
//
// One byte is accepted per cycle while no waiting route stalls the input. A
// byte is held in an input register, then scanned while the result register
// is written, so a route is given from the result register.
// The result register holds a waiting route; one more byte can enter the
// input register behind it, and then chars.ready stays low until routes
// takes the route. Reset starts in the header section with an
// empty line.
// ----------------------------------------------------------------------------
module subtitle_line_router (
	input  logic        clk,
	input  logic        arst_n,
	slr_char_if.sink    chars,
	slr_route_if.source routes
);
	import slr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       flush_s1;
	logic       out_free;
	logic       fire;
	logic       line_end;
	line_sum_t  summary;

	assign chars.ready = !valid_s1 || out_free;
	assign fire        = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			byte_s1  <= chars.byte_req;
			flush_s1 <= chars.flush;
		end
	end

	slr_line_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.byte_req (byte_s1),
		.flush    (flush_s1),
		.line_end (line_end),
		.summary  (summary)
	);

	slr_section_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.line_end  (line_end),
		.summary   (summary),
		.out_ready (routes.ready),
		.out_free  (out_free),
		.out_valid (routes.valid),
		.route     (routes.route),
		.section   (routes.section)
	);

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Subtitle line router testbench
// Streams script bytes into the router and checks every route decision
// against a cycle-free model of the section tracker and line scanner.
// Both channels idle at random, and one stretch runs with no idling.
// ----------------------------------------------------------------------------
module tb_top;
	import slr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	localparam logic [63:0] EVENTS_TXT   = "[Events]";
	localparam logic [71:0] DIALOGUE_TXT = "Dialogue:";

	typedef struct packed {
		logic [1:0] route;
		logic [1:0] section;
	} decision_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	slr_char_if  char_ch();
	slr_route_if route_ch();

	subtitle_line_router dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (char_ch),
		.routes (route_ch)
	);

	bit        idle_enable = 1'b1;
	int        fault_count = 0;
	int        cycle_count = 0;
	int        items_sent = 0;
	decision_t decisions_due[$];

	// Model of the section tracker and of the line being scanned.
	logic [1:0] sec_now;
	logic [3:0] ln_len;
	logic [3:0] ln_dlg_pos;
	logic       ln_hdr_ok;
	logic       ln_lead;
	logic       ln_dlg_bad;
	logic       ln_bracket;
	logic       ln_tag;
	logic       ln_cr;
	logic [7:0] ln_older;
	logic [7:0] ln_newer;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit is_p(input logic [7:0] c);
		return c == CH_P_LO || c == CH_P_UP;
	endfunction

	function automatic logic [7:0] hdr_word_byte(input int i);
		return EVENTS_TXT[63 - 8 * i -: 8];
	endfunction

	function automatic logic [7:0] dlg_word_byte(input int i);
		return DIALOGUE_TXT[71 - 8 * i -: 8];
	endfunction

	function void clear_scan();
		ln_len = 4'd0;
		ln_dlg_pos = 4'd0;
		ln_hdr_ok = 1'b1;
		ln_lead = 1'b1;
		ln_dlg_bad = 1'b0;
		ln_bracket = 1'b0;
		ln_tag = 1'b0;
		ln_cr = 1'b0;
		ln_older = 8'h00;
		ln_newer = 8'h00;
	endfunction

	function void scan_byte(input logic [7:0] c);
		// A drawing tag only counts when all three bytes belong to this line.
		if (ln_len >= 4'd2) begin
			if (ln_older == CH_LBRACE && ln_newer == CH_BSLASH && is_p(c))
				ln_tag = 1'b1;
			if (ln_older == CH_BSLASH && is_p(ln_newer) && c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
				ln_tag = 1'b1;
		end
		if (ln_len < EVENTS_LEN) begin
			if (c != hdr_word_byte(int'(ln_len)))
				ln_hdr_ok = 1'b0;
		end else begin
			ln_hdr_ok = 1'b0;
		end
		if (ln_len == 4'd0 && c == CH_LBRACKET)
			ln_bracket = 1'b1;
		if (!(ln_lead && (c == CH_SPACE || c == CH_TAB))) begin
			ln_lead = 1'b0;
			if (!ln_dlg_bad && ln_dlg_pos < DIALOGUE_LEN) begin
				if (c == dlg_word_byte(int'(ln_dlg_pos)))
					ln_dlg_pos = ln_dlg_pos + 4'd1;
				else
					ln_dlg_bad = 1'b1;
			end
		end
		ln_older = ln_newer;
		ln_newer = c;
		if (ln_len < LEN_MAX)
			ln_len = ln_len + 4'd1;
	endfunction

	function void close_line();
		decision_t d;
		d.route = ROUTE_BOTH;
		case (sec_now)
			SEC_CODE_HEADER: begin
				if (ln_hdr_ok && ln_len == EVENTS_LEN)
					sec_now = SEC_CODE_EVENTS;
			end
			SEC_CODE_EVENTS: begin
				if (ln_bracket)
					sec_now = SEC_CODE_FOOTER;
				else if (!ln_dlg_bad && ln_dlg_pos == DIALOGUE_LEN)
					d.route = ln_tag ? ROUTE_EFFECT : ROUTE_TEXT;
			end
			default: sec_now = SEC_CODE_FOOTER;
		endcase
		d.section = sec_now;
		decisions_due.push_back(d);
		clear_scan();
	endfunction

	function void predict_item(input logic [7:0] b, input logic f);
		if (f) begin
			if (ln_len != 4'd0 || ln_cr)
				close_line();
		end else if (b == CH_NL) begin
			close_line();
		end else begin
			// A held carriage return turns into a plain byte once more follows.
			if (ln_cr) begin
				ln_cr = 1'b0;
				scan_byte(CH_CR);
			end
			if (b == CH_CR)
				ln_cr = 1'b1;
			else
				scan_byte(b);
		end
	endfunction

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("cycle %0d: %s", cycle_count, msg);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			route_ch.ready <= 1'b0;
		else
			route_ch.ready <= !idle_enable || ($urandom_range(99) >= 6);
	end

	always @(posedge clk) begin : route_check
		decision_t want;
		if (route_ch.valid && route_ch.ready) begin
			if (decisions_due.size() == 0) begin
				log_fault($sformatf("route %0d section %0d with no line pending",
					route_ch.route, route_ch.section));
			end else begin
				want = decisions_due.pop_front();
				if (route_ch.route !== want.route)
					log_fault($sformatf("route expected %0d, got %0d",
						want.route, route_ch.route));
				if (route_ch.section !== want.section)
					log_fault($sformatf("section expected %0d, got %0d",
						want.section, route_ch.section));
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic f);
		while (idle_enable && $urandom_range(99) < 6) begin
			char_ch.valid <= 1'b0;
			@(posedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.byte_req <= b;
		char_ch.flush <= f;
		@(posedge clk);
		while (!char_ch.ready)
			@(posedge clk);
		items_sent++;
		predict_item(b, f);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic send_line(input string s, input bit with_cr);
		send_text(s);
		if (with_cr)
			send_item(CH_CR, 1'b0);
		send_item(CH_NL, 1'b0);
	endtask

	// The byte that rides along with a flush must be ignored, so make it random.
	task automatic send_flush();
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic wait_drain();
		char_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (decisions_due.size() != 0);
	endtask

	// Bytes biased toward the characters that drawing tags are built from.
	// An opening bracket is kept out so that events lines never end the section.
	function automatic logic [7:0] rand_body_byte();
		int r;
		logic [7:0] c;
		r = $urandom_range(99);
		if (r < 10)
			c = CH_LBRACE;
		else if (r < 20)
			c = CH_BSLASH;
		else if (r < 28)
			c = CH_P_LO;
		else if (r < 32)
			c = CH_P_UP;
		else if (r < 44)
			c = CH_DIGIT_0 + 8'($urandom_range(9));
		else if (r < 49)
			c = CH_CR;
		else if (r < 55)
			c = $urandom_range(1) ? CH_SPACE : CH_TAB;
		else if (r < 65)
			c = 8'($urandom_range(128, 255));
		else
			c = 8'($urandom_range(32, 126));
		if (c == CH_LBRACKET)
			c = 8'h28;
		return c;
	endfunction

	function automatic logic [7:0] rand_noise_byte();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		if (c == CH_LBRACKET)
			c = 8'h5D;
		return c;
	endfunction

	task automatic test_header_section();
		int k;
		send_line("", 1'b0);
		send_line("[Events", 1'b0);
		send_line("[Events]x", 1'b0);
		send_line("[events]", 1'b0);
		send_line("Dialogue:{\\p1}", 1'b0);
		send_item(CH_CR, 1'b0);
		send_line("[Events]", 1'b0);
		// Near misses of the section marker.
		repeat (12) begin
			k = $urandom_range(8);
			for (int i = 0; i < k; i++)
				send_item(hdr_word_byte(i), 1'b0);
			repeat ((k == 8) ? $urandom_range(1, 3) : $urandom_range(3)) begin
				send_item(rand_noise_byte(), 1'b0);
			end
			send_item(CH_NL, 1'b0);
		end
		send_line("[Events]", 1'b1);
	endtask

	task automatic test_dialogue_routing();
		send_line("Dialogue: 0,0:00:01.00,Default,,Hello", 1'b0);
		send_line(" \t Dialogue:x", 1'b1);
		send_line("Dialogue:", 1'b0);
		send_line("Dialogue", 1'b0);
		send_line("dialogue: lower", 1'b0);
		send_line("Comment: 0,{\\p1}", 1'b0);
		send_line("x Dialogue:", 1'b0);
		send_line("Dialogue: [sign] {\\p1}", 1'b0);
		send_line("", 1'b0);
		send_item(8'hFF, 1'b0);
		send_line("Dialogue:", 1'b0);
	endtask

	task automatic test_drawing_tags();
		send_line("Dialogue:{\\p1}m 0 0 l 10 10", 1'b0);
		send_line("Dialogue:{\\P", 1'b0);
		send_line("Dialogue:\\p", 1'b0);
		send_line("Dialogue:\\P7", 1'b0);
		send_line("Dialogue:\\p7", 1'b1);
		send_line("Dialogue:\\pp", 1'b0);
		send_line("Dialogue: a rather long line \\p0", 1'b0);
		send_line("{\\p1}", 1'b0);
		// A carriage return in the middle breaks the tag.
		send_text("Dialogue:{\\");
		send_item(CH_CR, 1'b0);
		send_line("p", 1'b0);
	endtask

	task automatic test_line_ends();
		send_flush();
		send_text("Dialogue:\\p9");
		send_flush();
		send_flush();
		send_item(CH_CR, 1'b0);
		send_flush();
		send_item(CH_CR, 1'b0);
		send_item(CH_CR, 1'b0);
		send_item(CH_NL, 1'b0);
		send_line("", 1'b1);
	endtask

	task automatic send_random_event_line();
		int kind;
		int cut;
		int nbody;
		int r;
		kind = $urandom_range(99);
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 3))
				send_item($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
		end
		if (kind < 65) begin
			for (int i = 0; i < 9; i++)
				send_item(dlg_word_byte(i), 1'b0);
		end else if (kind < 80) begin
			cut = $urandom_range(8);
			for (int i = 0; i < 9; i++) begin
				if (i == cut)
					send_item(rand_body_byte(), 1'b0);
				else if (kind >= 72 || i < cut)
					send_item(dlg_word_byte(i), 1'b0);
			end
		end else if (kind < 90) begin
			send_text("Comment:");
		end else begin
			repeat ($urandom_range(1, 20))
				send_item(rand_noise_byte(), 1'b0);
		end
		nbody = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(8);
		for (int i = 0; i < nbody; i++) begin
			if ($urandom_range(15) == 0) begin
				if ($urandom_range(1)) begin
					send_text("{\\");
					send_item($urandom_range(1) ? CH_P_LO : CH_P_UP, 1'b0);
				end else begin
					send_item(CH_BSLASH, 1'b0);
					send_item($urandom_range(1) ? CH_P_LO : CH_P_UP, 1'b0);
					send_item(CH_DIGIT_0 + 8'($urandom_range(9)), 1'b0);
				end
			end else begin
				send_item(rand_body_byte(), 1'b0);
			end
		end
		r = $urandom_range(99);
		if (r < 15) begin
			send_item(CH_CR, 1'b0);
			send_item(CH_NL, 1'b0);
		end else if (r < 20) begin
			send_flush();
			if (r < 22)
				send_flush();
		end else begin
			send_item(CH_NL, 1'b0);
		end
	endtask

	task automatic test_random_events(input int target);
		int stop;
		int quiet_end;
		int pause_at;
		bit paused;
		stop = items_sent + target;
		quiet_end = items_sent + target / 4;
		pause_at = items_sent + target / 2;
		paused = 1'b0;
		idle_enable = 1'b0;
		while (items_sent < stop) begin
			if (items_sent >= quiet_end)
				idle_enable = 1'b1;
			if (!paused && items_sent >= pause_at) begin
				wait_drain();
				paused = 1'b1;
			end
			send_random_event_line();
		end
		idle_enable = 1'b1;
	endtask

	task automatic test_footer(input int target);
		int stop;
		send_line("[Fonts]", 1'b0);
		send_line("[Events]", 1'b0);
		send_line("Dialogue:{\\p1}", 1'b0);
		stop = items_sent + target;
		while (items_sent < stop) begin
			repeat ($urandom_range(15))
				send_item(8'($urandom_range(255)), 1'b0);
			if ($urandom_range(4) == 0)
				send_item(CH_CR, 1'b0);
			send_item(CH_NL, 1'b0);
		end
		send_text("tail");
		send_flush();
	endtask

	initial begin
		char_ch.valid <= 1'b0;
		char_ch.byte_req <= 8'h00;
		char_ch.flush <= 1'b0;
		sec_now = SEC_CODE_HEADER;
		clear_scan();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_section();
		test_dialogue_routing();
		test_drawing_tags();
		test_line_ends();
		test_random_events(1250);
		test_footer(150);

		char_ch.valid <= 1'b0;
		while (decisions_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: subtitle_line_router.f
hdl/slr_pkg.sv
hdl/slr_char_if.sv
hdl/slr_route_if.sv
hdl/slr_line_scan.sv
hdl/slr_section_track.sv
hdl/subtitle_line_router.sv
tb/sv/tb_top.sv
